>>> design/stss_pkg.sv
`default_nettype none

package stss_pkg;

  // Limits of the scan geometry
  localparam int unsigned MaxTiles  = 256;
  localparam int unsigned MaxLabels = 8;
  localparam int unsigned MaxSlices = 1024;

  // Configuration register widths
  localparam int unsigned TilesW   = 9;
  localparam int unsigned LabelsW  = 4;
  localparam int unsigned SlicesW  = 11;
  localparam int unsigned DirsW    = 3;
  localparam int unsigned PitchW   = 20;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 20;

  // Result field widths
  localparam int unsigned ActionW = 2;
  localparam int unsigned SliceW  = 10;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned OffW    = 28;
  localparam int unsigned StackW  = 29;
  localparam int unsigned LabelW  = 3;
  localparam int unsigned ZOffW   = 30;

  // Stream word widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutFieldsW = SliceW + 2 * IdxW + 2 * OffW + StackW + LabelW + 1 + ZOffW;
  localparam int unsigned OutDataW = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [ActionW-1:0] {
    ACT_MOVE    = 2'd0,
    ACT_ACQUIRE = 2'd1,
    ACT_SAVE    = 2'd2,
    ACT_CUT     = 2'd3
  } action_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_TILES_X      = 3'd0,
    REG_TILES_Y      = 3'd1,
    REG_LABEL_COUNT  = 3'd2,
    REG_SLICE_COUNT  = 3'd3,
    REG_INITIAL_DIRS = 3'd4,
    REG_PITCH_X      = 3'd5,
    REG_PITCH_Y      = 3'd6,
    REG_Z_ADVANCE    = 3'd7
  } cfg_reg_e;

  // One result word before packing
  typedef struct packed {
    logic [ZOffW-1:0]   z_offset;
    logic               z_dir;
    logic [LabelW-1:0]  label_index;
    logic [StackW-1:0]  stack_number;
    logic [OffW-1:0]    offset_y;
    logic [OffW-1:0]    offset_x;
    logic [IdxW-1:0]    tile_j;
    logic [IdxW-1:0]    tile_i;
    logic [SliceW-1:0]  slice_number;
  } result_t;

endpackage

`default_nettype wire

>>> design/serpentine_tile_scan_sequencer_unit.sv
// Serpentine tile scan sequencer. Every word taken on the slave stream returns
// one scan command on the master stream: move, acquire and save for each tile,
// tiles in serpentine order per label, labels per slice, and a cut between
// slices. Bit 0 of s_axis_tdata restarts the run before the command is made.
// Once the final save (tlast high) is out, further words without restart give
// no command. One word per clock while the master side takes each command; the command is built
// from the sequence counters in the accept cycle and held in the output
// register, which frees as the master side takes it. A configuration write
// restarts the run; write only while the block is idle.
`default_nettype none

module serpentine_tile_scan_sequencer_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [stss_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [stss_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [stss_pkg::InDataW-1:0]    s_axis_tdata,   // [0] restart, rest zero
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // slice_number, tile_i, tile_j, offset_x, offset_y, stack_number,
  // label_index, z_dir, z_offset, zero fill
  output      logic [stss_pkg::OutDataW-1:0]   m_axis_tdata,
  output      logic [stss_pkg::ActionW-1:0]    m_axis_tuser,   // action
  output      logic                            m_axis_tlast    // last
);

  import stss_pkg::*;

  typedef enum logic [1:0] {
    PH_MOVE = 2'd0,
    PH_ACQ  = 2'd1,
    PH_SAVE = 2'd2,
    PH_CUT  = 2'd3
  } phase_e;

  // Configuration
  logic [TilesW-1:0]  tiles_x_q, tiles_y_q;
  logic [LabelsW-1:0] label_count_q;
  logic [SlicesW-1:0] slice_count_q;
  logic [DirsW-1:0]   init_dirs_q;
  logic [PitchW-1:0]  pitch_x_q, pitch_y_q, z_adv_q;

  // Sequence state
  logic [SliceW-1:0] slice_q, slice_d;
  logic [LabelW-1:0] label_q, label_d;
  logic [IdxW-1:0]   col_q, col_d, row_q, row_d;
  logic [DirsW-1:0]  dir_q, dir_d;
  phase_e            phase_q, phase_d;
  logic [StackW-1:0] stack_q, stack_d;
  logic [ZOffW-1:0]  z_q, z_d;
  logic              fin_q, fin_d;
  logic              pend_q;      // restart owed after reset or config write

  // Output register
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;
  action_e           act_q, act_d;
  logic              last_q, last_d;

  logic [TilesW-1:0]  tx, ty;
  logic [LabelsW-1:0] nl;
  logic [SlicesW-1:0] ns;
  logic [IdxW-1:0]    col0, row0;
  logic               accept, restart;

  // Effective state after an optional restart
  logic [SliceW-1:0] slice_c;
  logic [LabelW-1:0] label_c;
  logic [IdxW-1:0]   col_c, row_c;
  logic [DirsW-1:0]  dir_c;
  phase_e            phase_c;
  logic [StackW-1:0] stack_c;
  logic [ZOffW-1:0]  z_c;
  logic              fin_c;

  logic signed [IdxW+1:0]        dx, dy;
  logic signed [IdxW+PitchW+2:0] px, py;
  logic signed [IdxW+PitchW+2:0] hx, hy;
  logic [ZOffW:0]                z_sum;
  logic [TilesW-1:0]             col_inc, row_inc;
  logic [LabelsW-1:0]            label_inc;
  logic [SlicesW-1:0]            slice_inc;

  assign tx = (tiles_x_q == '0) ? TilesW'(1) :
              (tiles_x_q > TilesW'(MaxTiles)) ? TilesW'(MaxTiles) : tiles_x_q;
  assign ty = (tiles_y_q == '0) ? TilesW'(1) :
              (tiles_y_q > TilesW'(MaxTiles)) ? TilesW'(MaxTiles) : tiles_y_q;
  assign nl = (label_count_q == '0) ? LabelsW'(1) :
              (label_count_q > LabelsW'(MaxLabels)) ? LabelsW'(MaxLabels) : label_count_q;
  assign ns = (slice_count_q == '0) ? SlicesW'(1) :
              (slice_count_q > SlicesW'(MaxSlices)) ? SlicesW'(MaxSlices) : slice_count_q;

  // Start corner: a positive direction starts at the far end and counts down
  assign col0 = init_dirs_q[0] ? IdxW'(tx - TilesW'(1)) : '0;
  assign row0 = init_dirs_q[1] ? IdxW'(ty - TilesW'(1)) : '0;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign restart       = s_axis_tdata[0] || pend_q;

  always_comb begin
    if (restart) begin
      slice_c = '0;
      label_c = '0;
      col_c   = col0;
      row_c   = row0;
      dir_c   = init_dirs_q;
      phase_c = PH_MOVE;
      stack_c = '0;
      z_c     = '0;
      fin_c   = 1'b0;
    end else begin
      slice_c = slice_q;
      label_c = label_q;
      col_c   = col_q;
      row_c   = row_q;
      dir_c   = dir_q;
      phase_c = phase_q;
      stack_c = stack_q;
      z_c     = z_q;
      fin_c   = fin_q;
    end

    // Tile centre: pitch * ((n-1) - 2*idx) / 2, halved toward zero
    dx = (IdxW+2)'($signed({2'b00, tx})) - (IdxW+2)'(1) - (IdxW+2)'($signed({1'b0, col_c, 1'b0}));
    dy = (IdxW+2)'($signed({2'b00, ty})) - (IdxW+2)'(1) - (IdxW+2)'($signed({1'b0, row_c, 1'b0}));
    px = dx * $signed({1'b0, pitch_x_q});
    py = dy * $signed({1'b0, pitch_y_q});
    hx = (px + ((px < 0) ? (IdxW+PitchW+3)'(1) : '0)) >>> 1;
    hy = (py + ((py < 0) ? (IdxW+PitchW+3)'(1) : '0)) >>> 1;

    z_sum     = {1'b0, z_c} + (ZOffW+1)'(z_adv_q);
    col_inc   = {1'b0, col_c} + TilesW'(1);
    row_inc   = {1'b0, row_c} + TilesW'(1);
    label_inc = {1'b0, label_c} + LabelsW'(1);
    slice_inc = {1'b0, slice_c} + SlicesW'(1);

    slice_d = slice_c;
    label_d = label_c;
    col_d   = col_c;
    row_d   = row_c;
    dir_d   = dir_c;
    phase_d = phase_c;
    stack_d = stack_c;
    z_d     = z_c;
    fin_d   = fin_c;

    res_d              = '0;
    res_d.slice_number = slice_c;
    last_d             = 1'b0;
    act_d              = ACT_MOVE;

    unique case (phase_c)
      PH_MOVE: begin
        act_d          = ACT_MOVE;
        res_d.tile_i   = col_c;
        res_d.tile_j   = row_c;
        res_d.offset_x = OffW'(hx);
        res_d.offset_y = OffW'(hy);
        phase_d        = PH_ACQ;
      end
      PH_ACQ: begin
        act_d              = ACT_ACQUIRE;
        res_d.stack_number = stack_c;
        res_d.label_index  = label_c;
        res_d.z_dir        = dir_c[2];
        res_d.z_offset     = z_c;
        stack_d            = stack_c + StackW'(1);
        dir_d[2]           = !dir_c[2];
        phase_d            = PH_SAVE;
      end
      PH_SAVE: begin
        act_d   = ACT_SAVE;
        phase_d = PH_MOVE;
        if (dir_c[0] && col_c != '0) begin
          col_d = col_c - IdxW'(1);
        end else if (!dir_c[0] && col_inc < tx) begin
          col_d = IdxW'(col_inc);
        end else begin
          // row end: X reverses, step Y
          dir_d[0] = !dir_c[0];
          if (dir_c[1] && row_c != '0) begin
            row_d = row_c - IdxW'(1);
          end else if (!dir_c[1] && row_inc < ty) begin
            row_d = IdxW'(row_inc);
          end else begin
            // label pass done: Y reverses
            dir_d[1] = !dir_c[1];
            label_d  = LabelW'(label_inc);
            if (label_inc >= nl) begin
              if (slice_inc < ns) begin
                phase_d = PH_CUT;
              end else begin
                last_d = 1'b1;
                fin_d  = 1'b1;
              end
            end
          end
        end
      end
      PH_CUT: begin
        act_d   = ACT_CUT;
        slice_d = SliceW'(slice_inc);
        z_d     = z_sum[ZOffW] ? {ZOffW{1'b1}} : z_sum[ZOffW-1:0];
        dir_d   = init_dirs_q;
        col_d   = col0;
        row_d   = row0;
        label_d = '0;
        phase_d = PH_MOVE;
      end
    endcase

    if (accept) begin
      out_valid_d = !fin_c;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_x_q     <= TilesW'(1);
      tiles_y_q     <= TilesW'(1);
      label_count_q <= LabelsW'(1);
      slice_count_q <= SlicesW'(1);
      init_dirs_q   <= '0;
      pitch_x_q     <= '0;
      pitch_y_q     <= '0;
      z_adv_q       <= '0;
      slice_q       <= '0;
      label_q       <= '0;
      col_q         <= '0;
      row_q         <= '0;
      dir_q         <= '0;
      phase_q       <= PH_MOVE;
      stack_q       <= '0;
      z_q           <= '0;
      fin_q         <= 1'b0;
      pend_q        <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        slice_q <= slice_d;
        label_q <= label_d;
        col_q   <= col_d;
        row_q   <= row_d;
        dir_q   <= dir_d;
        phase_q <= phase_d;
        stack_q <= stack_d;
        z_q     <= z_d;
        fin_q   <= fin_d;
      end
      if (cfg_we_i) begin
        pend_q <= 1'b1;
      end else if (accept) begin
        pend_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          REG_TILES_X:      tiles_x_q     <= cfg_data_i[TilesW-1:0];
          REG_TILES_Y:      tiles_y_q     <= cfg_data_i[TilesW-1:0];
          REG_LABEL_COUNT:  label_count_q <= cfg_data_i[LabelsW-1:0];
          REG_SLICE_COUNT:  slice_count_q <= cfg_data_i[SlicesW-1:0];
          REG_INITIAL_DIRS: init_dirs_q   <= cfg_data_i[DirsW-1:0];
          REG_PITCH_X:      pitch_x_q     <= cfg_data_i[PitchW-1:0];
          REG_PITCH_Y:      pitch_y_q     <= cfg_data_i[PitchW-1:0];
          REG_Z_ADVANCE:    z_adv_q       <= cfg_data_i[PitchW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= res_d;
      act_q  <= act_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(res_q);
  assign m_axis_tuser  = act_q;
  assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire
